// ----- design/layer_z_order_manager_top_defines.svh -----
// ---------------------------------------------------------------------------
// layer_z_order_manager_top_defines.svh
// Assertion macros for the layer z-order manager. Each macro expects clk and
// arst_n in scope. Build with NO_ASSERTIONS defined to drop them.
// ---------------------------------------------------------------------------
`ifndef LAYER_Z_ORDER_MANAGER_TOP_DEFINES_SVH
`define LAYER_Z_ORDER_MANAGER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LZO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LZO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LZO_ASSERT_NOW(lbl, ante, cons, msg)
`define LZO_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- design/lzo_pkg.sv -----
// ---------------------------------------------------------------------------
// lzo_pkg
// Shared sizes, codes and control structs of the layer z-order manager.
// ---------------------------------------------------------------------------
`default_nettype none

package lzo_pkg;

	localparam int NUM_LAYERS = 32;
	localparam int LAY_W      = $clog2(NUM_LAYERS);
	localparam int LVL_W      = LAY_W + 1;   // signed level, -1 = hidden
	localparam int CMP_W      = LVL_W + 1;   // room for top+1 and clamp math

	typedef logic [LAY_W-1:0]        lay_t;
	typedef logic signed [LVL_W-1:0] lvl_t;
	typedef logic signed [CMP_W-1:0] cmp_t;

	localparam lvl_t LVL_HIDDEN = '1;
	localparam cmp_t CMP_HIDDEN = '1;

	typedef enum logic [1:0] {
		REQ_ALLOC  = 2'd0,
		REQ_SET    = 2'd1,
		REQ_FREE   = 2'd2,
		REQ_LOOKUP = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_EMPTY  = 2'd2
	} status_e_t;

	// control broadcast to the level cells
	typedef struct packed {
		logic en;      // shift window active
		logic up;      // 1: take from level below, 0: from level above
		cmp_t lo;
		cmp_t hi;
		logic ld;      // load moved layer
		lay_t ld_lvl;
		lay_t ld_lay;
	} lvl_ctl_t;

	// control broadcast to the layer cells
	typedef struct packed {
		logic alloc;
		lay_t alloc_idx;
		logic mv;      // addressed layer takes new level
		lay_t sel;
		cmp_t new_lvl;
		logic rel;     // release after move
		logic en;      // renumber window active
		logic up;      // 1: +1, 0: -1
		cmp_t lo;
		cmp_t hi;
	} lay_ctl_t;

endpackage

`default_nettype wire

// ----- design/lzo_level_cell.sv -----
// ---------------------------------------------------------------------------
// lzo_level_cell
// One stacking level: holds the layer shown at it, takes its neighbor's
// layer when a move shifts the stack, or loads the moved layer.
// ---------------------------------------------------------------------------
`default_nettype none

module lzo_level_cell
	import lzo_pkg::*;
(
	input  logic     clk,
	input  lay_t     idx,
	input  lvl_ctl_t ctl,
	input  lay_t     below,
	input  lay_t     above,
	output lay_t     lay
);

	lay_t lay_q;
	cmp_t me;

	assign me  = cmp_t'({2'b00, idx});
	assign lay = lay_q;

	always_ff @(posedge clk) begin
		if (ctl.ld && idx == ctl.ld_lvl) begin
			lay_q <= ctl.ld_lay;
		end else if (ctl.en && me >= ctl.lo && me <= ctl.hi) begin
			lay_q <= ctl.up ? below : above;
		end
	end

endmodule

`default_nettype wire

// ----- design/lzo_layer_cell.sv -----
// ---------------------------------------------------------------------------
// lzo_layer_cell
// One layer slot: in-use flag and current level, renumbered in place when
// the stack shifts around a moved layer.
// ---------------------------------------------------------------------------
`default_nettype none

module lzo_layer_cell
	import lzo_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  lay_t     idx,
	input  lay_ctl_t ctl,
	output logic     in_use,
	output lvl_t     level
);

	logic use_q;
	lvl_t lvl_q;
	cmp_t lv;

	assign lv     = cmp_t'(lvl_q);
	assign in_use = use_q;
	assign level  = lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_q <= 1'b0;
			lvl_q <= LVL_HIDDEN;
		end else if (ctl.alloc && idx == ctl.alloc_idx) begin
			use_q <= 1'b1;
			lvl_q <= LVL_HIDDEN;
		end else if (ctl.mv && idx == ctl.sel) begin
			lvl_q <= lvl_t'(ctl.new_lvl);
			if (ctl.rel) begin
				use_q <= 1'b0;
			end
		end else if (ctl.en && lv >= ctl.lo && lv <= ctl.hi) begin
			lvl_q <= ctl.up ? lvl_q + lvl_t'(1) : lvl_q - lvl_t'(1);
		end
	end

endmodule

`default_nettype wire

// ----- design/layer_z_order_manager_top.sv -----
// ---------------------------------------------------------------------------
// layer_z_order_manager_top
// Layer pool with z-order stack: allocate, set height, free, lookup.
// ---------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  request   | start / busy       | req_type, layer_sel, height_req
//  result    | done (1-cycle)     | status, layer_out, layer_height,
//            |                    | stack_top, repaint
//
//  For each transaction, the accept edge registers the request
//  together with the lookups done on the port values (slot level, clamped
//  height, lowest free slot, layer at a level); the next edge updates the
//  level-cell chain and the layer cells in parallel and registers the result.
//  busy is high for the one cycle between; done pulses for one cycle after.
//  A new start may be taken in the same cycle the result is shown.
//  Reset: all slots free, all levels hidden, stack top -1; level contents
//  are undefined until written. The result side cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

`include "layer_z_order_manager_top_defines.svh"

module layer_z_order_manager_top
	import lzo_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        req_type,
	input  logic [4:0]        layer_sel,
	input  logic signed [6:0] height_req,
	output logic              done,
	output logic [1:0]        status,
	output logic [4:0]        layer_out,
	output logic signed [5:0] layer_height,
	output logic signed [5:0] stack_top,
	output logic              repaint
);

	// cell rows
	lay_t     lvl_lay_w [NUM_LAYERS];
	logic     use_w     [NUM_LAYERS];
	lvl_t     lay_lvl_w [NUM_LAYERS];
	lvl_ctl_t lvl_ctl;
	lay_ctl_t lay_ctl;

	// control state
	logic pend_q;
	lvl_t top_q;

	// request stage
	req_e_t req_s1;
	lay_t   sel_s1;
	logic   ok_s1;
	lvl_t   old_s1;
	cmp_t   h_s1;
	logic   afound_s1;
	lay_t   aidx_s1;
	logic   lhit_s1;
	lay_t   llay_s1;
	lay_t   llvl_s1;

	// result registers
	logic      done_q;
	status_e_t status_q;
	lay_t      lay_out_q;
	lvl_t      lay_h_q;
	logic      rep_q;

	// accept-side combinational
	logic   acc;
	req_e_t req_in;
	cmp_t   top7;
	cmp_t   old_in;
	cmp_t   hr_in;
	cmp_t   lim_in;
	cmp_t   h_in;
	logic   sel_ok_in;
	logic   afound_in;
	lay_t   aidx_in;
	logic   lhit_in;

	// execute-side combinational
	cmp_t old7;
	logic mv;
	logic chg;
	lvl_t top_n;

	assign acc    = start && !pend_q;
	assign busy   = pend_q;
	assign req_in = req_e_t'(req_type);
	assign top7   = cmp_t'(top_q);

	// ---------------------------------------------------------------------
	// Cell chains
	// ---------------------------------------------------------------------
	for (genvar g = 0; g < NUM_LAYERS; g++) begin : g_cells
		lay_t below_w;
		lay_t above_w;

		if (g == 0) begin : g_bot
			assign below_w = '0;
		end else begin : g_mid_b
			assign below_w = lvl_lay_w[g-1];
		end
		if (g == NUM_LAYERS - 1) begin : g_top
			assign above_w = '0;
		end else begin : g_mid_a
			assign above_w = lvl_lay_w[g+1];
		end

		lzo_level_cell u_lvl (
			.clk   (clk),
			.idx   (lay_t'(g)),
			.ctl   (lvl_ctl),
			.below (below_w),
			.above (above_w),
			.lay   (lvl_lay_w[g])
		);

		lzo_layer_cell u_lay (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (lay_t'(g)),
			.ctl    (lay_ctl),
			.in_use (use_w[g]),
			.level  (lay_lvl_w[g])
		);
	end

	// ---------------------------------------------------------------------
	// Accept side: clamp height, find free slot, read level for lookup
	// ---------------------------------------------------------------------
	always_comb begin
		sel_ok_in = (int'(layer_sel) < NUM_LAYERS) && use_w[layer_sel];
		old_in    = cmp_t'(lay_lvl_w[layer_sel]);
		// free = move to hidden first
		hr_in     = (req_in == REQ_FREE) ? CMP_HIDDEN : cmp_t'(height_req);
		// shown layer may reach top, hidden one top+1
		lim_in    = (old_in >= 0) ? top7 : top7 + cmp_t'(1);
		if (hr_in < CMP_HIDDEN) begin
			h_in = CMP_HIDDEN;
		end else if (hr_in > lim_in) begin
			h_in = lim_in;
		end else begin
			h_in = hr_in;
		end
		lhit_in = (height_req >= 0) && (cmp_t'(height_req) <= top7);
	end

	// lowest free slot
	always_comb begin
		afound_in = 1'b0;
		aidx_in   = '0;
		for (int i = NUM_LAYERS - 1; i >= 0; i--) begin
			if (!use_w[i]) begin
				afound_in = 1'b1;
				aidx_in   = lay_t'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1    <= req_in;
			sel_s1    <= layer_sel;
			ok_s1     <= sel_ok_in;
			old_s1    <= lvl_t'(old_in);
			h_s1      <= h_in;
			afound_s1 <= afound_in;
			aidx_s1   <= aidx_in;
			lhit_s1   <= lhit_in;
			llay_s1   <= lvl_lay_w[height_req[LAY_W-1:0]];
			llvl_s1   <= height_req[LAY_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Execute: shift windows for the cell rows
	//   down-move (h >= 0): levels h..old-1 rise by one
	//   hide:               levels old+1..top drop by one, top-1
	//   up-move:            levels old+1..h drop by one
	//   show:               levels h..top rise by one, top+1
	// ---------------------------------------------------------------------
	always_comb begin
		old7    = cmp_t'(old_s1);
		mv      = pend_q && ok_s1 && (req_s1 == REQ_SET || req_s1 == REQ_FREE);
		chg     = mv && (h_s1 != old7);
		top_n   = top_q;
		lvl_ctl = '0;
		lay_ctl = '0;

		lay_ctl.alloc     = pend_q && (req_s1 == REQ_ALLOC) && afound_s1;
		lay_ctl.alloc_idx = aidx_s1;
		lay_ctl.mv        = mv;
		lay_ctl.sel       = sel_s1;
		lay_ctl.new_lvl   = h_s1;
		lay_ctl.rel       = (req_s1 == REQ_FREE);

		lvl_ctl.ld_lvl = lay_t'(h_s1);
		lvl_ctl.ld_lay = sel_s1;

		if (chg) begin
			lvl_ctl.en = 1'b1;
			lay_ctl.en = 1'b1;
			lvl_ctl.ld = (h_s1 >= 0);
			if (old7 > h_s1) begin
				if (h_s1 >= 0) begin
					lvl_ctl.up = 1'b1;
					lvl_ctl.lo = h_s1 + cmp_t'(1);
					lvl_ctl.hi = old7;
					lay_ctl.up = 1'b1;
					lay_ctl.lo = h_s1;
					lay_ctl.hi = old7 - cmp_t'(1);
				end else begin
					lvl_ctl.up = 1'b0;
					lvl_ctl.lo = old7;
					lvl_ctl.hi = top7 - cmp_t'(1);
					lay_ctl.up = 1'b0;
					lay_ctl.lo = old7 + cmp_t'(1);
					lay_ctl.hi = top7;
					top_n      = top_q - lvl_t'(1);
				end
			end else begin
				if (old7 >= 0) begin
					lvl_ctl.up = 1'b0;
					lvl_ctl.lo = old7;
					lvl_ctl.hi = h_s1 - cmp_t'(1);
					lay_ctl.up = 1'b0;
					lay_ctl.lo = old7 + cmp_t'(1);
					lay_ctl.hi = h_s1;
				end else begin
					lvl_ctl.up = 1'b1;
					lvl_ctl.lo = h_s1 + cmp_t'(1);
					lvl_ctl.hi = top7 + cmp_t'(1);
					lay_ctl.up = 1'b1;
					lay_ctl.lo = h_s1;
					lay_ctl.hi = top7;
					top_n      = top_q + lvl_t'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			done_q <= 1'b0;
			top_q  <= LVL_HIDDEN;
		end else begin
			pend_q <= acc;
			done_q <= pend_q;
			if (pend_q) begin
				top_q <= top_n;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pend_q) begin
			case (req_s1)
				REQ_ALLOC: begin
					status_q  <= afound_s1 ? ST_OK : ST_NOFREE;
					lay_out_q <= afound_s1 ? aidx_s1 : '0;
					lay_h_q   <= LVL_HIDDEN;
					rep_q     <= 1'b0;
				end
				REQ_SET, REQ_FREE: begin
					status_q  <= ST_OK;
					lay_out_q <= sel_s1;
					lay_h_q   <= ok_s1 ? lvl_t'(h_s1) : LVL_HIDDEN;
					rep_q     <= chg;
				end
				REQ_LOOKUP: begin
					status_q  <= lhit_s1 ? ST_OK : ST_EMPTY;
					lay_out_q <= lhit_s1 ? llay_s1 : '0;
					lay_h_q   <= lhit_s1 ? lvl_t'({1'b0, llvl_s1}) : LVL_HIDDEN;
					rep_q     <= 1'b0;
				end
				default: begin
					status_q  <= ST_OK;
					lay_out_q <= '0;
					lay_h_q   <= LVL_HIDDEN;
					rep_q     <= 1'b0;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign layer_out    = lay_out_q;
	assign layer_height = lay_h_q;
	assign stack_top    = top_q;
	assign repaint      = rep_q;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	logic [NUM_LAYERS-1:0] shown_w;
	logic [CMP_W-1:0]      top_p1;

	always_comb begin
		for (int i = 0; i < NUM_LAYERS; i++) begin
			shown_w[i] = (lay_lvl_w[i] >= 0);
		end
	end
	assign top_p1 = CMP_W'(top7 + cmp_t'(1));

	`LZO_ASSERT_NEXT(a_pend_done, pend_q, done_q, "result strobe missing after execute")
	`LZO_ASSERT_NOW(a_done_idle, done_q, !pend_q, "result shown while still executing")
	`LZO_ASSERT_NEXT(a_top_hold, !pend_q, $stable(top_q), "stack top moved outside execute")
	`LZO_ASSERT_NOW(a_top_count, 1'b1, CMP_W'($countones(shown_w)) == top_p1, "shown count != top+1")

endmodule

`default_nettype wire

// ----- test/tb_layer_z_order_manager_top.sv -----
// ---------------------------------------------------------------------------
// tb_layer_z_order_manager_top
// Self-checking bench for the layer z-order stack. A short table of
// hand-picked requests covers reset state, clamping, hide/show, free and
// out-of-range lookups. Random traffic then cycles through fill, churn and
// drain phases. Every result is checked against a z-order stack model
// kept inside the bench, or against its table row's values where given.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_layer_z_order_manager_top
	import lzo_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_ITEMS  = 180;
	localparam int NDIR         = 25;

	// one result transaction as seen on the output ports
	typedef struct packed {
		status_e_t status;
		lay_t      layer;
		lvl_t      height;
		lvl_t      top;
		logic      repaint;
	} zres_t;

	// directed stimulus row; exp is only used when typed is set
	typedef struct packed {
		req_e_t            req;
		lay_t              sel;
		logic signed [6:0] hreq;
		logic              typed;
		zres_t             exp;
	} zrow_t;

	localparam zres_t NO_RES = '{ST_OK, 5'd0, LVL_HIDDEN, LVL_HIDDEN, 1'b0};

	// Directed table. State comments track the stack bottom to top.
	localparam zrow_t DIR_ROWS [NDIR] = '{
		// reset state: nothing shown, every lookup empty
		'{REQ_LOOKUP, 5'd0,  7'sd0,   1'b1, '{ST_EMPTY, 5'd0, LVL_HIDDEN, LVL_HIDDEN, 1'b0}},
		// set height / free on slots never allocated are ignored
		'{REQ_SET,    5'd31, 7'sd63,  1'b1, '{ST_OK, 5'd31, LVL_HIDDEN, LVL_HIDDEN, 1'b0}},
		'{REQ_FREE,   5'd0,  7'sd0,   1'b1, '{ST_OK, 5'd0,  LVL_HIDDEN, LVL_HIDDEN, 1'b0}},
		// allocate hands out the lowest free slots, hidden
		'{REQ_ALLOC,  5'd0,  7'sd0,   1'b1, '{ST_OK, 5'd0,  LVL_HIDDEN, LVL_HIDDEN, 1'b0}},
		'{REQ_ALLOC,  5'd0,  7'sd0,   1'b1, '{ST_OK, 5'd1,  LVL_HIDDEN, LVL_HIDDEN, 1'b0}},
		// max height on a hidden layer clamps to top+1 = 0
		'{REQ_SET,    5'd0,  7'sd63,  1'b1, '{ST_OK, 5'd0,  6'sd0, 6'sd0, 1'b1}},
		// most negative height clamps to hidden, already hidden: no repaint
		'{REQ_SET,    5'd1,  -7'sd64, 1'b1, '{ST_OK, 5'd1,  LVL_HIDDEN, 6'sd0, 1'b0}},
		'{REQ_SET,    5'd1,  7'sd63,  1'b0, NO_RES},   // [0 1]
		'{REQ_ALLOC,  5'd0,  7'sd0,   1'b0, NO_RES},
		'{REQ_SET,    5'd2,  7'sd0,   1'b0, NO_RES},   // insert at bottom: [2 0 1]
		// lookups above top and below zero
		'{REQ_LOOKUP, 5'd0,  7'sd63,  1'b1, '{ST_EMPTY, 5'd0, LVL_HIDDEN, 6'sd2, 1'b0}},
		'{REQ_LOOKUP, 5'd0,  -7'sd64, 1'b1, '{ST_EMPTY, 5'd0, LVL_HIDDEN, 6'sd2, 1'b0}},
		'{REQ_LOOKUP, 5'd0,  -7'sd1,  1'b0, NO_RES},
		'{REQ_SET,    5'd2,  7'sd63,  1'b0, NO_RES},   // shown clamps to top: [0 1 2]
		'{REQ_SET,    5'd2,  7'sd2,   1'b0, NO_RES},   // same height, no repaint
		'{REQ_SET,    5'd0,  7'sd1,   1'b0, NO_RES},   // [1 0 2]
		'{REQ_LOOKUP, 5'd0,  7'sd0,   1'b0, NO_RES},
		'{REQ_LOOKUP, 5'd0,  7'sd2,   1'b0, NO_RES},
		'{REQ_FREE,   5'd1,  7'sd0,   1'b0, NO_RES},   // free of shown layer: [0 2]
		'{REQ_FREE,   5'd1,  7'sd0,   1'b1, '{ST_OK, 5'd1, LVL_HIDDEN, 6'sd1, 1'b0}},
		'{REQ_ALLOC,  5'd0,  7'sd0,   1'b0, NO_RES},   // slot 1 reused
		'{REQ_FREE,   5'd1,  7'sd0,   1'b0, NO_RES},   // free of hidden layer
		'{REQ_SET,    5'd0,  -7'sd1,  1'b0, NO_RES},   // hide bottom: [2]
		'{REQ_SET,    5'd2,  -7'sd5,  1'b0, NO_RES},   // hide last, top back to -1
		'{REQ_LOOKUP, 5'd0,  7'sd0,   1'b1, '{ST_EMPTY, 5'd0, LVL_HIDDEN, LVL_HIDDEN, 1'b0}}
	};

	// DUT ports
	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        req_type;
	logic [4:0]        layer_sel;
	logic signed [6:0] height_req;
	logic              done;
	logic [1:0]        status;
	logic [4:0]        layer_out;
	logic signed [5:0] layer_height;
	logic signed [5:0] stack_top;
	logic              repaint;

	layer_z_order_manager_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.layer_sel    (layer_sel),
		.height_req   (height_req),
		.done         (done),
		.status       (status),
		.layer_out    (layer_out),
		.layer_height (layer_height),
		.stack_top    (stack_top),
		.repaint      (repaint)
	);

	// Stack model: slot flags, per-layer level, per-level layer, top.
	bit    slot_used [NUM_LAYERS];
	int    level_of  [NUM_LAYERS];
	int    layer_at  [NUM_LAYERS];
	int    top_lvl;

	zres_t pending_results [$];

	int    fail_count;
	int    cycle_count;
	int    burst_left;
	int    op_count [4];
	int    nofree_count;
	int    repaint_count;
	int    checked_count;
	int    peak_top;

	// ------------------------------------------------------------------
	// Clock: 10 ns period
	// ------------------------------------------------------------------
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Model of one move: clamp, then shift the layers between old and
	// new level by one so that every shown layer's height = its level.
	// ------------------------------------------------------------------
	function automatic void restack(int lay, int req_h);
		int old_lvl;
		int h;
		int lv;

		old_lvl = level_of[lay];
		h = req_h;
		if (h < -1)
			h = -1;
		// a shown layer can go no higher than top; a hidden one to top+1
		if (old_lvl >= 0) begin
			if (h > top_lvl)
				h = top_lvl;
		end else begin
			if (h > top_lvl + 1)
				h = top_lvl + 1;
		end
		if (h == old_lvl)
			return;
		level_of[lay] = h;

		if (old_lvl > h) begin
			if (h >= 0) begin
				// moving down: layers in [h, old) move up one
				for (lv = old_lvl; lv > h; lv--) begin
					layer_at[lv] = layer_at[lv-1];
					level_of[layer_at[lv]] = lv;
				end
				layer_at[h] = lay;
			end else begin
				// hiding: layers above close the gap
				for (lv = old_lvl; lv < top_lvl; lv++) begin
					layer_at[lv] = layer_at[lv+1];
					level_of[layer_at[lv]] = lv;
				end
				top_lvl--;
			end
		end else begin
			if (old_lvl >= 0) begin
				// moving up: layers in (old, h] move down one
				for (lv = old_lvl; lv < h; lv++) begin
					layer_at[lv] = layer_at[lv+1];
					level_of[layer_at[lv]] = lv;
				end
				layer_at[h] = lay;
			end else begin
				// showing: layers at h and above make room
				for (lv = top_lvl; lv >= h; lv--) begin
					layer_at[lv+1] = layer_at[lv];
					level_of[layer_at[lv+1]] = lv + 1;
				end
				layer_at[h] = lay;
				top_lvl++;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Expected result of one request; updates the model state.
	// ------------------------------------------------------------------
	function automatic zres_t predict_zorder(req_e_t rq, lay_t sl, logic signed [6:0] hr);
		zres_t r;
		int    hv;
		int    prev;
		int    i;

		hv = int'(hr);
		r.status  = ST_OK;
		r.layer   = '0;
		r.height  = LVL_HIDDEN;
		r.repaint = 1'b0;

		case (rq)
			REQ_ALLOC: begin
				r.status = ST_NOFREE;
				for (i = 0; i < NUM_LAYERS; i++) begin
					if (!slot_used[i]) begin
						slot_used[i] = 1'b1;
						level_of[i]  = -1;
						r.status     = ST_OK;
						r.layer      = lay_t'(i);
						break;
					end
				end
			end
			REQ_SET, REQ_FREE: begin
				r.layer = sl;
				// unused slots are ignored
				if (slot_used[sl]) begin
					prev = level_of[sl];
					restack(int'(sl), (rq == REQ_SET) ? hv : -1);
					r.height  = lvl_t'(level_of[sl]);
					r.repaint = (level_of[sl] != prev);
					if (rq == REQ_FREE)
						slot_used[sl] = 1'b0;
				end
			end
			default: begin
				if (hv >= 0 && hv <= top_lvl) begin
					r.layer  = lay_t'(layer_at[hv]);
					r.height = lvl_t'(hv);
				end else begin
					r.status = ST_EMPTY;
				end
			end
		endcase
		r.top = lvl_t'(top_lvl);
		return r;
	endfunction

	// idle gap before the next request; occasional back-to-back bursts
	function automatic int pick_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	// ------------------------------------------------------------------
	// Driver: called at a falling edge, returns at a falling edge.
	// start is only lowered when there is a real gap, so a back-to-back
	// request never sees start dropped and raised in one time step.
	// ------------------------------------------------------------------
	task automatic send_request(req_e_t rq, lay_t sl, logic signed [6:0] hr,
			bit typed, zres_t typed_res);
		int    gap;
		zres_t pred;

		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start      <= 1'b1;
		req_type   <= rq;
		layer_sel  <= sl;
		height_req <= hr;
		// busy only moves on rising edges, so it is stable here
		while (busy)
			@(negedge clk);
		@(posedge clk);
		// transaction accepted at this edge
		pred = predict_zorder(rq, sl, hr);
		pending_results.push_back(typed ? typed_res : pred);
		op_count[rq]++;
		if (pred.status == ST_NOFREE)
			nofree_count++;
		if (pred.repaint)
			repaint_count++;
		if (top_lvl > peak_top)
			peak_top = top_lvl;
		@(negedge clk);
	endtask

	// hold the sender off until every outstanding result has come back
	task automatic drain_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Random request with a mix given in weights per operation.
	// Most set/free requests address slots in use, most heights sit
	// near the current stack so that real moves happen.
	// ------------------------------------------------------------------
	task automatic send_random(int w_alloc, int w_set, int w_free);
		int   pick;
		int   used_list [$];
		int   i;
		int   hv;
		req_e_t rq;
		lay_t sl;
		logic signed [6:0] hr;

		pick = $urandom_range(0, 99);
		if (pick < w_alloc)
			rq = REQ_ALLOC;
		else if (pick < w_alloc + w_set)
			rq = REQ_SET;
		else if (pick < w_alloc + w_set + w_free)
			rq = REQ_FREE;
		else
			rq = REQ_LOOKUP;

		for (i = 0; i < NUM_LAYERS; i++)
			if (slot_used[i])
				used_list.push_back(i);
		if (used_list.size() != 0 && $urandom_range(0, 3) != 0)
			sl = lay_t'(used_list[$urandom_range(0, used_list.size() - 1)]);
		else
			sl = lay_t'($urandom_range(0, NUM_LAYERS - 1));

		case ($urandom_range(0, 9))
			0:       hv = $urandom_range(0, 127) - 64;
			1:       hv = -1;
			default: hv = $urandom_range(0, top_lvl + 3) - 1;
		endcase
		hr = 7'(hv);

		send_request(rq, sl, hr, 1'b0, NO_RES);
	endtask

	// ------------------------------------------------------------------
	// Result checker: done is a one-cycle strobe, sampled on rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		zres_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected");
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				checked_count++;
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					fail_count++;
				end
				if (layer_out !== e.layer) begin
					$error("layer_out: expected %0d, got %0d", e.layer, layer_out);
					fail_count++;
				end
				if (layer_height !== e.height) begin
					$error("layer_height: expected %0d, got %0d", e.height, layer_height);
					fail_count++;
				end
				if (stack_top !== e.top) begin
					$error("stack_top: expected %0d, got %0d", e.top, stack_top);
					fail_count++;
				end
				if (repaint !== e.repaint) begin
					$error("repaint: expected %0d, got %0d", e.repaint, repaint);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int k;
		int ph;

		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = REQ_ALLOC;
		layer_sel  = '0;
		height_req = '0;
		fail_count    = 0;
		cycle_count   = 0;
		burst_left    = 0;
		nofree_count  = 0;
		repaint_count = 0;
		checked_count = 0;
		peak_top      = -1;
		foreach (op_count[i])
			op_count[i] = 0;
		for (k = 0; k < NUM_LAYERS; k++) begin
			slot_used[k] = 1'b0;
			level_of[k]  = -1;
			layer_at[k]  = 0;
		end
		top_lvl = -1;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (k = 0; k < NDIR; k++)
			send_request(DIR_ROWS[k].req, DIR_ROWS[k].sel, DIR_ROWS[k].hreq,
				DIR_ROWS[k].typed, DIR_ROWS[k].exp);
		drain_results();

		// random: fill (pool runs out), churn, drain; repeated
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			for (k = 0; k < PHASE_ITEMS; k++) begin
				case (ph % 3)
					0:       send_random(45, 35, 5);
					1:       send_random(15, 40, 20);
					default: send_random(5, 35, 40);
				endcase
			end
			// sender holds off until the pipe is empty
			drain_results();
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered: %0d alloc, %0d set, %0d free, %0d lookup; %0d results checked",
			op_count[REQ_ALLOC], op_count[REQ_SET], op_count[REQ_FREE],
			op_count[REQ_LOOKUP], checked_count);
		$display("pool exhausted %0d times, %0d repaints, deepest stack top %0d",
			nofree_count, repaint_count, peak_top);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
